>>> design/gha_pkg.sv
// Package with shared types and constants of the generational handle allocator.
package gha_pkg;
   localparam int MaxSlots = 1024;
   localparam int GenBits = 16;
   localparam int IdxBits = $clog2(MaxSlots);
   localparam int CntBits = $clog2(MaxSlots + 1);

   localparam logic [1:0] OP_CREATE = 2'd0;
   localparam logic [1:0] OP_MARK = 2'd1;
   localparam logic [1:0] OP_PROCESS = 2'd2;
   localparam logic [1:0] OP_QUERY = 2'd3;

   localparam logic [1:0] ST_DONE = 2'd0;
   localparam logic [1:0] ST_FULL = 2'd1;
   localparam logic [1:0] ST_NOT_ALIVE = 2'd2;
   localparam logic [1:0] ST_PENDING = 2'd3;

   typedef struct packed {
      logic [1:0] opcode;
      logic [15:0] entity_index;
      logic [15:0] entity_generation;
      logic idx_ok;
   } cmd_type;
endpackage

>>> design/gha_ram.sv
// Generic single-port RAM with registered read data.
module gha_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input logic clock,
   input logic wr_en,
   input logic [$clog2(Depth)-1:0] addr,
   input logic [Width-1:0] wr_data,
   output logic [Width-1:0] rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule

>>> design/gha_front.sv
// Front end: accepts request items, classifies them and feeds a two-entry queue.
module gha_front (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   input logic [1:0] req_opcode,
   input logic [15:0] req_entity_index,
   input logic [15:0] req_entity_generation,
   output logic cmd_valid,
   input logic cmd_take,
   output gha_pkg::cmd_type cmd
);
   gha_pkg::cmd_type q_ff [2];
   gha_pkg::cmd_type q_in;
   logic [1:0] cnt_ff;
   logic [1:0] cnt_in;
   logic push;
   logic pop;

   assign req_stall = (cnt_ff == 2'd2);
   assign push = req_valid && !req_stall;
   assign pop = cmd_valid && cmd_take;
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd = q_ff[0];

   always_comb begin
      q_in.opcode = req_opcode;
      q_in.entity_index = req_entity_index;
      q_in.entity_generation = req_entity_generation;
      q_in.idx_ok = ({16'd0, req_entity_index} < 32'(gha_pkg::MaxSlots));
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
      if (pop) begin
         q_ff[0] <= q_ff[1];
      end
      if (push) begin
         if (cnt_ff == 2'd0 || (cnt_ff == 2'd1 && pop)) begin
            q_ff[0] <= q_in;
         end else begin
            q_ff[1] <= q_in;
         end
      end
   end

   assert property (@(posedge clock) disable iff (reset) cnt_ff != 2'd3)
      else $error("queue count out of range");
endmodule

>>> design/gha_back.sv
// Back end: executes commands against slot state with a serial sweep for deferred frees.
module gha_back (
   input logic clock,
   input logic reset,
   input logic cmd_valid,
   output logic cmd_take,
   input gha_pkg::cmd_type cmd,
   output logic rsp_valid,
   input logic rsp_stall,
   output logic [1:0] rsp_status,
   output logic [9:0] rsp_handle_index,
   output logic [15:0] rsp_handle_generation,
   output logic rsp_is_alive,
   output logic [10:0] rsp_alive_total,
   output logic [10:0] rsp_slots_in_use,
   output logic [10:0] rsp_freed_total
);
   localparam int IB = gha_pkg::IdxBits;
   localparam int CB = gha_pkg::CntBits;
   localparam int GB = gha_pkg::GenBits;
   localparam int NS = gha_pkg::MaxSlots;
   localparam int RW = GB + 2;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_READ = 3'd1;
   localparam logic [2:0] S_EXEC = 3'd2;
   localparam logic [2:0] S_SCAN = 3'd3;
   localparam logic [2:0] S_SWEEP = 3'd4;
   localparam logic [2:0] S_SWRD = 3'd5;
   localparam logic [2:0] S_OUT = 3'd6;

   logic [2:0] st_ff, st_in;
   logic [CB-1:0] hw_ff, hw_in;
   logic [CB-1:0] ac_ff, ac_in;
   logic [CB-1:0] freed_ff, freed_in;
   gha_pkg::cmd_type c_ff, c_in;
   logic [CB-1:0] ptr_ff, ptr_in;
   logic [IB-1:0] pick_ff, pick_in;
   logic [1:0] status_ff, status_in;
   logic [IB-1:0] hidx_ff, hidx_in;
   logic [GB-1:0] hgen_ff, hgen_in;
   logic isal_ff, isal_in;
   logic ov_ff, ov_in;

   logic ram_we;
   logic [IB-1:0] ram_addr;
   logic [RW-1:0] ram_wd, ram_rd;
   logic rd_alive;
   logic rd_pend;
   logic [GB-1:0] rd_gen;
   logic [IB-1:0] cidx;
   logic in_range;
   logic hit;

   // Each slot entry holds its alive flag, its pending flag and its generation. Entries
   // below the high-water mark have all been written since reset.
   gha_ram #(.Width(RW), .Depth(NS)) u_slot (
      .clock(clock), .wr_en(ram_we), .addr(ram_addr), .wr_data(ram_wd), .rd_data(ram_rd)
   );

   assign rd_alive = ram_rd[RW-1];
   assign rd_pend = ram_rd[RW-2];
   assign rd_gen = ram_rd[GB-1:0];

   assign cidx = c_ff.entity_index[IB-1:0];
   assign in_range = c_ff.idx_ok && ({16'd0, c_ff.entity_index} < 32'(hw_ff));
   assign hit = in_range && rd_alive && (rd_gen == c_ff.entity_generation[GB-1:0]);

   assign cmd_take = (st_ff == S_IDLE) && !ov_ff;
   assign rsp_valid = ov_ff;

   always_comb begin
      st_in = st_ff;
      hw_in = hw_ff;
      ac_in = ac_ff;
      freed_in = freed_ff;
      c_in = c_ff;
      ptr_in = ptr_ff;
      pick_in = pick_ff;
      status_in = status_ff;
      hidx_in = hidx_ff;
      hgen_in = hgen_ff;
      isal_in = isal_ff;
      ov_in = ov_ff && rsp_stall;
      ram_we = 1'b0;
      ram_addr = cidx;
      ram_wd = {1'b0, 1'b0, rd_gen};
      case (st_ff)
         S_IDLE: begin
            if (cmd_valid && !ov_ff) begin
               c_in = cmd;
               ptr_in = '0;
               freed_in = '0;
               status_in = gha_pkg::ST_DONE;
               hidx_in = '0;
               hgen_in = '0;
               isal_in = 1'b0;
               st_in = (cmd.opcode == gha_pkg::OP_PROCESS) ? S_SWEEP : S_READ;
            end
         end
         S_READ: begin
            if (c_ff.opcode == gha_pkg::OP_CREATE) begin
               if (ac_ff == hw_ff) begin
                  if (hw_ff == CB'(NS)) begin
                     status_in = gha_pkg::ST_FULL;
                  end else begin
                     ram_we = 1'b1;
                     ram_addr = IB'(hw_ff);
                     ram_wd = {1'b1, 1'b0, GB'(0)};
                     hidx_in = IB'(hw_ff);
                     hw_in = hw_ff + CB'(1);
                     ac_in = ac_ff + CB'(1);
                  end
                  st_in = S_OUT;
               end else begin
                  ram_addr = '0;
                  pick_in = '0;
                  ptr_in = CB'(1);
                  st_in = S_SCAN;
               end
            end else begin
               st_in = S_EXEC;
            end
         end
         S_EXEC: begin
            case (c_ff.opcode)
               gha_pkg::OP_MARK: begin
                  if (!hit) status_in = gha_pkg::ST_NOT_ALIVE;
                  else if (rd_pend) status_in = gha_pkg::ST_PENDING;
                  else begin
                     ram_we = 1'b1;
                     ram_wd = {1'b1, 1'b1, rd_gen};
                  end
               end
               gha_pkg::OP_QUERY: isal_in = hit;
               default: ;
            endcase
            st_in = S_OUT;
         end
         S_SCAN: begin
            if (!rd_alive) begin
               ram_we = 1'b1;
               ram_addr = pick_ff;
               ram_wd = {1'b1, 1'b0, rd_gen};
               ac_in = ac_ff + CB'(1);
               hidx_in = pick_ff;
               hgen_in = rd_gen;
               st_in = S_OUT;
            end else begin
               ram_addr = ptr_ff[IB-1:0];
               pick_in = ptr_ff[IB-1:0];
               ptr_in = ptr_ff + CB'(1);
            end
         end
         S_SWEEP: begin
            if (ptr_ff >= hw_ff) begin
               st_in = S_OUT;
            end else begin
               ram_addr = ptr_ff[IB-1:0];
               st_in = S_SWRD;
            end
         end
         S_SWRD: begin
            ram_addr = ptr_ff[IB-1:0];
            if (rd_pend) begin
               ram_we = 1'b1;
               if (rd_alive) begin
                  ram_wd = {1'b0, 1'b0, rd_gen + GB'(1)};
                  if (ac_ff != '0) ac_in = ac_ff - CB'(1);
                  freed_in = freed_ff + CB'(1);
               end
            end
            ptr_in = ptr_ff + CB'(1);
            st_in = S_SWEEP;
         end
         S_OUT: begin
            ov_in = 1'b1;
            st_in = S_IDLE;
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
         hw_ff <= '0;
         ac_ff <= '0;
         ov_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         hw_ff <= hw_in;
         ac_ff <= ac_in;
         ov_ff <= ov_in;
      end
      freed_ff <= freed_in;
      c_ff <= c_in;
      ptr_ff <= ptr_in;
      pick_ff <= pick_in;
      status_ff <= status_in;
      hidx_ff <= hidx_in;
      hgen_ff <= hgen_in;
      isal_ff <= isal_in;
   end

   assign rsp_status = status_ff;
   assign rsp_handle_index = 10'(hidx_ff);
   assign rsp_handle_generation = 16'(hgen_ff);
   assign rsp_is_alive = isal_ff;
   assign rsp_alive_total = 11'(ac_ff);
   assign rsp_slots_in_use = 11'(hw_ff);
   assign rsp_freed_total = 11'(freed_ff);

   assert property (@(posedge clock) disable iff (reset) ac_ff <= hw_ff)
      else $error("alive count above high-water mark");
   assert property (@(posedge clock) disable iff (reset) hw_ff <= CB'(NS))
      else $error("high-water mark above table size");
   assert property (@(posedge clock) disable iff (reset)
      (ov_ff && rsp_stall) |=> ov_ff && $stable(status_ff))
      else $error("stalled result changed");
   assert property (@(posedge clock) disable iff (reset)
      (st_ff == S_SWRD) |-> (ptr_ff < hw_ff))
      else $error("sweep beyond high-water mark");
endmodule

>>> design/generational_handle_allocator.sv
// Top level of the generational handle allocator.
// Mark and query items pass through read, execute and output states. A create that takes
// a new slot or finds the table full goes from read to output, one that reuses a slot scans
// from slot 0 to the first free one, and process deferred destroys sweeps the slots below
// the high-water mark. The back end holds one item; the next leaves the two-entry queue the
// cycle after the result is taken, so no new item is taken before the last one is through.
// Synchronous reset clears the counters; a slot's state is written when first handed out.
module generational_handle_allocator (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   input logic [1:0] req_opcode,
   input logic [15:0] req_entity_index,
   input logic [15:0] req_entity_generation,
   output logic rsp_valid,
   input logic rsp_stall,
   output logic [1:0] rsp_status,
   output logic [9:0] rsp_handle_index,
   output logic [15:0] rsp_handle_generation,
   output logic rsp_is_alive,
   output logic [10:0] rsp_alive_total,
   output logic [10:0] rsp_slots_in_use,
   output logic [10:0] rsp_freed_total
);
   gha_pkg::cmd_type cmd;
   logic cmd_valid;
   logic cmd_take;

   gha_front u_front (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .req_opcode(req_opcode), .req_entity_index(req_entity_index),
      .req_entity_generation(req_entity_generation),
      .cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd(cmd)
   );

   gha_back u_back (
      .clock(clock), .reset(reset), .cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd(cmd),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_status(rsp_status),
      .rsp_handle_index(rsp_handle_index), .rsp_handle_generation(rsp_handle_generation),
      .rsp_is_alive(rsp_is_alive), .rsp_alive_total(rsp_alive_total),
      .rsp_slots_in_use(rsp_slots_in_use), .rsp_freed_total(rsp_freed_total)
   );
endmodule

>>> tb/generational_handle_allocator_tb.sv
// Testbench of the generational handle allocator: random and directed items checked against a model.
`timescale 1ns / 1ps
module generational_handle_allocator_tb;
   typedef struct packed {
      logic [1:0] status;
      logic [9:0] handle_index;
      logic [15:0] handle_generation;
      logic is_alive;
      logic [10:0] alive_total;
      logic [10:0] slots_in_use;
      logic [10:0] freed_total;
   } answer_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0] req_opcode = gha_pkg::OP_QUERY;
   logic [15:0] req_entity_index = '0;
   logic [15:0] req_entity_generation = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [1:0] rsp_status;
   logic [9:0] rsp_handle_index;
   logic [15:0] rsp_handle_generation;
   logic rsp_is_alive;
   logic [10:0] rsp_alive_total;
   logic [10:0] rsp_slots_in_use;
   logic [10:0] rsp_freed_total;

   logic [15:0] gen_table [gha_pkg::MaxSlots];
   logic alive_table [gha_pkg::MaxSlots];
   logic pending_table [gha_pkg::MaxSlots];
   int unsigned high_mark;
   int unsigned live_slots;
   answer_type answers [$];
   int errors = 0;
   int idle_cycles = 0;
   bit quiet = 1'b0;
   bit done_sending = 1'b0;

   generational_handle_allocator dut (.*);

   always #5 clock = ~clock;

   function automatic bit handle_live(int unsigned idx, logic [15:0] gen);
      if (idx >= high_mark) return 1'b0;
      return alive_table[idx] && gen_table[idx] == gen;
   endfunction

   function automatic answer_type predict_answer(logic [1:0] op, logic [15:0] idx,
                                                 logic [15:0] gen);
      answer_type a;
      int pick;
      a = '0;
      case (op)
         gha_pkg::OP_CREATE: begin
            pick = -1;
            for (int i = 0; i < high_mark; i++)
               if (!alive_table[i] && pick < 0) pick = i;
            if (pick < 0 && high_mark >= gha_pkg::MaxSlots) begin
               a.status = gha_pkg::ST_FULL;
            end else begin
               if (pick < 0) begin
                  pick = int'(high_mark);
                  high_mark++;
               end
               alive_table[pick] = 1'b1;
               pending_table[pick] = 1'b0;
               live_slots++;
               a.handle_index = pick[9:0];
               a.handle_generation = gen_table[pick];
            end
         end
         gha_pkg::OP_MARK: begin
            if (!handle_live(32'(idx), gen)) a.status = gha_pkg::ST_NOT_ALIVE;
            else if (pending_table[idx]) a.status = gha_pkg::ST_PENDING;
            else pending_table[idx] = 1'b1;
         end
         gha_pkg::OP_PROCESS: begin
            for (int i = 0; i < high_mark; i++) begin
               if (pending_table[i] && alive_table[i]) begin
                  alive_table[i] = 1'b0;
                  gen_table[i] = gen_table[i] + 16'd1;
                  if (live_slots > 0) live_slots--;
                  a.freed_total++;
               end
               pending_table[i] = 1'b0;
            end
         end
         default: a.is_alive = handle_live(32'(idx), gen);
      endcase
      a.alive_total = live_slots[10:0];
      a.slots_in_use = high_mark[10:0];
      return a;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      errors++;
   endtask

   task automatic send_item(logic [1:0] op, logic [15:0] idx, logic [15:0] gen);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_entity_index <= idx;
      req_entity_generation <= gen;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      answers.insert(answers.size(), predict_answer(op, idx, gen));
   endtask

   task automatic pause_sending();
      req_valid <= 1'b0;
      @(posedge clock);
      while (answers.size() != 0) @(posedge clock);
   endtask

   function automatic logic [15:0] pick_index();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 16'($urandom);
      if (high_mark == 0 || r == 1) return 16'(high_mark + $urandom_range(0, 3));
      return 16'($urandom_range(0, high_mark - 1));
   endfunction

   task automatic random_item(int create_weight);
      int r;
      logic [15:0] idx;
      logic [15:0] gen;
      r = $urandom_range(0, 99);
      idx = pick_index();
      gen = idx < gha_pkg::MaxSlots ? gen_table[idx[9:0]] : 16'($urandom);
      if ($urandom_range(0, 7) == 0) gen = 16'($urandom);
      else if ($urandom_range(0, 9) == 0) gen = gen + 16'd1;
      if (r < create_weight) send_item(gha_pkg::OP_CREATE, 16'($urandom), 16'($urandom));
      else if (r < create_weight + 30) send_item(gha_pkg::OP_MARK, idx, gen);
      else if (r < create_weight + 38)
         send_item(gha_pkg::OP_PROCESS, 16'($urandom), 16'($urandom));
      else send_item(gha_pkg::OP_QUERY, idx, gen);
   endtask

   task automatic test_directed();
      send_item(gha_pkg::OP_QUERY, 16'd0, 16'd0);
      send_item(gha_pkg::OP_MARK, 16'd0, 16'd0);
      send_item(gha_pkg::OP_PROCESS, 16'hffff, 16'hffff);
      send_item(gha_pkg::OP_CREATE, 16'hffff, 16'hffff);
      send_item(gha_pkg::OP_CREATE, 16'd0, 16'd0);
      send_item(gha_pkg::OP_CREATE, 16'd0, 16'd0);
      send_item(gha_pkg::OP_QUERY, 16'd1, 16'd0);
      send_item(gha_pkg::OP_QUERY, 16'd1, 16'd1);
      send_item(gha_pkg::OP_QUERY, 16'd3, 16'd0);
      send_item(gha_pkg::OP_QUERY, 16'hffff, 16'hffff);
      send_item(gha_pkg::OP_MARK, 16'd1, 16'd0);
      send_item(gha_pkg::OP_MARK, 16'd1, 16'd0);
      send_item(gha_pkg::OP_MARK, 16'd0, 16'hffff);
      send_item(gha_pkg::OP_MARK, 16'hffff, 16'd0);
      send_item(gha_pkg::OP_PROCESS, 16'd0, 16'd0);
      send_item(gha_pkg::OP_QUERY, 16'd1, 16'd0);
      send_item(gha_pkg::OP_MARK, 16'd1, 16'd0);
      send_item(gha_pkg::OP_CREATE, 16'd0, 16'd0);
      send_item(gha_pkg::OP_QUERY, 16'd1, 16'd1);
      pause_sending();
   endtask

   task automatic test_bulk_churn();
      for (int i = 0; i < 150; i++)
         send_item(gha_pkg::OP_CREATE, 16'($urandom), 16'($urandom));
      send_item(gha_pkg::OP_MARK, 16'd149, gen_table[149]);
      send_item(gha_pkg::OP_MARK, 16'd5, gen_table[5]);
      send_item(gha_pkg::OP_PROCESS, 16'd0, 16'd0);
      send_item(gha_pkg::OP_CREATE, 16'd0, 16'd0);
      send_item(gha_pkg::OP_CREATE, 16'd0, 16'd0);
      send_item(gha_pkg::OP_CREATE, 16'd0, 16'd0);
      for (int i = 0; i < 150; i++) send_item(gha_pkg::OP_MARK, i[15:0], gen_table[i]);
      send_item(gha_pkg::OP_PROCESS, 16'd0, 16'd0);
   endtask

   task automatic test_random_mix();
      for (int i = 0; i < 360; i++) begin
         if (i == 260) quiet = 1'b1;
         random_item(i < 150 ? 35 : 25);
      end
   endtask

   task automatic test_generation_reuse();
      for (int i = 0; i < 20; i++) begin
         send_item(gha_pkg::OP_MARK, 16'd0, gen_table[0]);
         send_item(gha_pkg::OP_PROCESS, 16'd0, 16'd0);
         send_item(gha_pkg::OP_CREATE, 16'd0, 16'd0);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && !quiet) begin
         if (rsp_stall) rsp_stall <= $urandom_range(0, 2) != 0;
         else rsp_stall <= $urandom_range(0, 7) == 0;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      answer_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (answers.size() == 0) begin
            report_mismatch("unexpected item", 1, 0);
         end else begin
            want = answers.pop_front();
            if (rsp_status !== want.status)
               report_mismatch("status", rsp_status, want.status);
            if (rsp_handle_index !== want.handle_index)
               report_mismatch("handle_index", rsp_handle_index, want.handle_index);
            if (rsp_handle_generation !== want.handle_generation)
               report_mismatch("handle_generation", rsp_handle_generation,
                               want.handle_generation);
            if (rsp_is_alive !== want.is_alive)
               report_mismatch("is_alive", rsp_is_alive, want.is_alive);
            if (rsp_alive_total !== want.alive_total)
               report_mismatch("alive_total", rsp_alive_total, want.alive_total);
            if (rsp_slots_in_use !== want.slots_in_use)
               report_mismatch("slots_in_use", rsp_slots_in_use, want.slots_in_use);
            if (rsp_freed_total !== want.freed_total)
               report_mismatch("freed_total", rsp_freed_total, want.freed_total);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (done_sending && answers.size() == 0)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles > 20000) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   initial begin
      for (int i = 0; i < gha_pkg::MaxSlots; i++) begin
         gen_table[i] = '0;
         alive_table[i] = 1'b0;
         pending_table[i] = 1'b0;
      end
      high_mark = 0;
      live_slots = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_generation_reuse();
      test_bulk_churn();
      test_random_mix();
      req_valid <= 1'b0;
      done_sending = 1'b1;
      @(posedge clock);
      while (answers.size() != 0) @(posedge clock);
      repeat (3000) @(posedge clock);
      if (errors == 0 && answers.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule

>>> files.f
design/gha_pkg.sv
design/gha_ram.sv
design/gha_front.sv
design/gha_back.sv
design/generational_handle_allocator.sv
tb/generational_handle_allocator_tb.sv
